// ----- hw/rtl/texture_slot_arena_allocator_top_defines.svh -----
// Assertion macros used by the allocator top level.
`ifndef TEXTURE_SLOT_ARENA_ALLOCATOR_TOP_DEFINES_SVH
`define TEXTURE_SLOT_ARENA_ALLOCATOR_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define TSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/tsa_pkg.sv -----
// Package: types and constants of the texture slot arena allocator.
package tsa_pkg;
   localparam int SLOT_COUNT_DEF  = 512;
   localparam int SECOND_BYTES_DEF = 2097152;
   localparam int ALIGN_BYTES_DEF  = 16;
   localparam int SPACE_MARGIN     = 65536;
   localparam logic [20:0] SIZE_MAX21 = 21'h1FFFFF;

   typedef enum logic [2:0] {
      ACT_CREATE = 3'd0, ACT_BIND = 3'd1, ACT_RESERVE = 3'd2,
      ACT_CLEAR = 3'd3, ACT_QUERY = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0, ST_REUSED = 2'd1, ST_OVERFLOW = 2'd2, ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE, FSM_MUL, FSM_READ, FSM_EVAL, FSM_WRITE, FSM_CLEAR,
      FSM_DIV, FSM_OUT
   } fsm_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [9:0]  slot;
      logic [9:0]  width;
      logic [9:0]  height;
      logic [2:0]  pixel_format;
      logic [20:0] query_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [8:0]  slot_out;
      logic        location_valid;
      logic        location_second_arena;
      logic [20:0] location_offset;
      logic [20:0] allocated_bytes;
      logic        can_hold;
      logic [6:0]  usage_percent;
      logic        space_available;
   } rsp_type;

   // One slot table entry as stored in memory.
   typedef struct packed {
      logic        valid;
      logic        second_arena;
      logic [21:0] offset;
      logic [20:0] size;
   } entry_type;
endpackage

// ----- hw/rtl/tsa_ram.sv -----
// Generic single-port RAM with registered read.
module tsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data_ff <= mem_ff[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/texture_slot_arena_allocator_top.sv -----
// Texture slot arena allocator top level.
// One transaction at a time. After the accepting edge a request walks MUL, READ,
// EVAL and WRITE, then the usage-percent divider (one quotient bit per cycle
// over a 30-bit numerator scaled by 100), then OUT, which loads the output
// register and raises rsp_valid. The FSM then returns to IDLE before it can
// take the next request. Clear skips READ/EVAL/WRITE and instead sweeps the
// slot table memory one entry per cycle before the divider and OUT. After
// reset the same sweep runs once with req_ready low; csr writes are taken
// throughout. The slot table is one synchronous RAM with a registered read;
// each request but clear does read, modify and write-back of at most one
// entry, and requests never overlap, so no forwarding is needed. A finished
// result sits in the output register while the next request is accepted.
// That request stalls in OUT until the previous result has been taken.
`include "texture_slot_arena_allocator_top_defines.svh"
module texture_slot_arena_allocator_top #(
   parameter int SLOT_COUNT = tsa_pkg::SLOT_COUNT_DEF,
   parameter int SECOND_ARENA_BYTES = tsa_pkg::SECOND_BYTES_DEF,
   parameter int ALIGN_BYTES = tsa_pkg::ALIGN_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsa_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [21:0]      csr_data
);
   localparam int AW = $clog2(SLOT_COUNT);
   localparam int CW = AW + 1;
   localparam logic [22:0] SECOND_B = 23'(SECOND_ARENA_BYTES);
   localparam logic [22:0] ALIGN_M1 = 23'(ALIGN_BYTES - 1);
   localparam logic [22:0] ALIGN_MASK = ~ALIGN_M1;
   localparam logic [CW-1:0] SLOT_MAX = CW'(SLOT_COUNT);
   localparam int DW = 30;

   tsa_pkg::fsm_type state_ff, state_in;
   tsa_pkg::req_type req_ff;
   tsa_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic [21:0]      first_bytes_ff;
   logic [21:0]      first_next_ff, second_next_ff;
   logic [AW-1:0]    latest_ff;
   logic [CW-1:0]    bound_ff;
   logic             bound_ok_ff;
   logic [AW-1:0]    sweep_ff;
   logic             reset_sweep_ff;
   logic [22:0]      need_ff;
   logic [AW-1:0]    sel_ff;
   logic             sel_ok_ff;
   logic [1:0]       status_ff;
   logic             hold_ff;
   tsa_pkg::entry_type wr_entry_ff;
   logic             wr_pend_ff;
   logic [19:0]      px_ff;
   // divider
   logic [DW-1:0]    rem_ff, quot_ff;
   logic [DW-1:0]    num_ff;
   logic [4:0]       dcnt_ff;

   tsa_pkg::entry_type rd_entry, ram_wdata;
   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   tsa_pkg::action_type act;

   tsa_ram #(.WIDTH($bits(tsa_pkg::entry_type)), .DEPTH(SLOT_COUNT)) u_table (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wdata),
      .rd_data(rd_entry)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == tsa_pkg::FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   wire req_fire = req_valid && req_ready;
   // Output register is free for a new result.
   wire out_go = !rsp_valid_ff || rsp_ready;
   assign act = tsa_pkg::action_type'(req_ff.action);

   // Arena arithmetic on the latched request size.
   wire first_ok  = first_next_ff <= first_bytes_ff;
   wire [22:0] first_free = first_ok ? 23'(first_bytes_ff - first_next_ff) : 23'd0;
   wire [22:0] second_free = 23'(SECOND_B - 23'(second_next_ff));
   wire first_fits  = first_ok && (first_free >= need_ff);
   wire second_fits = second_free >= need_ff;
   wire reuse = rd_entry.valid && (23'(rd_entry.size) >= need_ff);
   wire [22:0] total = 23'(first_bytes_ff) + SECOND_B;

   // Raw byte size of the texture from the registered pixel count.
   logic [22:0] raw;
   always_comb begin
      case (req_ff.pixel_format)
         3'd0: raw = 23'(px_ff >> 1);
         3'd1: raw = 23'(px_ff);
         3'd2: raw = 23'({px_ff, 1'b0});
         3'd3: raw = 23'({px_ff, 2'b0});
         default: raw = '0;
      endcase
   end
   wire [22:0] raw_q = (act == tsa_pkg::ACT_QUERY) ? 23'(req_ff.query_bytes) : raw;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsa_pkg::FSM_IDLE:  if (req_fire) state_in = tsa_pkg::FSM_MUL;
         tsa_pkg::FSM_MUL:   state_in = (act == tsa_pkg::ACT_CLEAR) ?
                                tsa_pkg::FSM_CLEAR : tsa_pkg::FSM_READ;
         tsa_pkg::FSM_READ:  state_in = tsa_pkg::FSM_EVAL;
         tsa_pkg::FSM_EVAL:  state_in = tsa_pkg::FSM_WRITE;
         tsa_pkg::FSM_WRITE: state_in = tsa_pkg::FSM_DIV;
         tsa_pkg::FSM_CLEAR: if (sweep_ff == AW'(SLOT_COUNT - 1))
                                state_in = (act == tsa_pkg::ACT_CLEAR && !reset_sweep_ff) ?
                                   tsa_pkg::FSM_DIV : tsa_pkg::FSM_IDLE;
         tsa_pkg::FSM_DIV:   if (dcnt_ff == 5'd0) state_in = tsa_pkg::FSM_OUT;
         tsa_pkg::FSM_OUT:   if (out_go) state_in = tsa_pkg::FSM_IDLE;
         default:            state_in = tsa_pkg::FSM_IDLE;
      endcase
   end

   // Memory port control.
   always_comb begin
      ram_we = 1'b0;
      ram_addr = sel_ff;
      ram_wdata = wr_entry_ff;
      unique case (state_ff)
         tsa_pkg::FSM_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = sweep_ff;
            ram_wdata = '0;
         end
         tsa_pkg::FSM_WRITE: ram_we = wr_pend_ff;
         default: ;
      endcase
   end

   wire [CW-1:0] lat_p1 = CW'(latest_ff) + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsa_pkg::FSM_CLEAR;
         reset_sweep_ff <= 1'b1;
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
         first_bytes_ff <= '0;
         first_next_ff <= '0;
         second_next_ff <= '0;
         latest_ff <= '0;
         bound_ff <= '0;
         bound_ok_ff <= 1'b1;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) first_bytes_ff <= csr_data;
         if (state_ff == tsa_pkg::FSM_OUT && out_go) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            tsa_pkg::FSM_IDLE: if (req_fire) begin
               req_ff <= req_data;
               px_ff <= 20'(req_data.width) * 20'(req_data.height);
               reset_sweep_ff <= 1'b0;
               wr_pend_ff <= 1'b0;
               hold_ff <= 1'b0;
            end
            tsa_pkg::FSM_MUL: begin
               need_ff <= (raw_q + ALIGN_M1) & ALIGN_MASK;
               sel_ok_ff <= 1'b0;
               status_ff <= tsa_pkg::ST_DONE;
               sel_ff <= '0;
               sweep_ff <= '0;
               unique case (act)
                  tsa_pkg::ACT_CREATE: begin
                     if (lat_p1 >= SLOT_MAX) begin
                        status_ff <= tsa_pkg::ST_IGNORED;
                        sel_ff <= latest_ff;
                     end else begin
                        latest_ff <= AW'(lat_p1);
                        sel_ff <= AW'(lat_p1);
                        bound_ff <= lat_p1;
                        bound_ok_ff <= 1'b1;
                        sel_ok_ff <= 1'b1;
                        wr_entry_ff <= '0;
                        wr_pend_ff <= 1'b1;
                     end
                  end
                  tsa_pkg::ACT_BIND, tsa_pkg::ACT_QUERY: begin
                     sel_ff <= AW'(req_ff.slot);
                     if (CW'(req_ff.slot) >= SLOT_MAX) begin
                        if (act == tsa_pkg::ACT_BIND) status_ff <= tsa_pkg::ST_IGNORED;
                     end else begin
                        sel_ok_ff <= 1'b1;
                        if (act == tsa_pkg::ACT_BIND) begin
                           bound_ff <= CW'(req_ff.slot);
                           bound_ok_ff <= 1'b1;
                        end
                     end
                  end
                  tsa_pkg::ACT_RESERVE: begin
                     if (!bound_ok_ff || bound_ff >= SLOT_MAX) begin
                        status_ff <= tsa_pkg::ST_IGNORED;
                     end else begin
                        sel_ff <= AW'(bound_ff);
                        sel_ok_ff <= 1'b1;
                     end
                  end
                  tsa_pkg::ACT_CLEAR: begin
                     first_next_ff <= '0;
                     second_next_ff <= '0;
                     latest_ff <= '0;
                     bound_ok_ff <= 1'b0;
                     bound_ff <= '0;
                  end
                  default: status_ff <= tsa_pkg::ST_IGNORED;
               endcase
            end
            tsa_pkg::FSM_EVAL: begin
               if (act == tsa_pkg::ACT_QUERY)
                  hold_ff <= (sel_ok_ff && reuse) || first_fits || second_fits;
               if (act == tsa_pkg::ACT_RESERVE && sel_ok_ff) begin
                  if (reuse) begin
                     status_ff <= tsa_pkg::ST_REUSED;
                     wr_entry_ff <= rd_entry;
                  end else begin
                     wr_pend_ff <= 1'b1;
                     wr_entry_ff.valid <= 1'b1;
                     wr_entry_ff.size <= (need_ff > 23'(tsa_pkg::SIZE_MAX21)) ?
                        tsa_pkg::SIZE_MAX21 : 21'(need_ff);
                     if (first_fits) begin
                        wr_entry_ff.second_arena <= 1'b0;
                        wr_entry_ff.offset <= first_next_ff;
                        first_next_ff <= 22'(23'(first_next_ff) + need_ff);
                     end else if (second_fits) begin
                        wr_entry_ff.second_arena <= 1'b1;
                        wr_entry_ff.offset <= second_next_ff;
                        second_next_ff <= 22'(23'(second_next_ff) + need_ff);
                     end else begin
                        wr_entry_ff.second_arena <= 1'b0;
                        wr_entry_ff.offset <= '0;
                        status_ff <= tsa_pkg::ST_OVERFLOW;
                     end
                  end
               end else if (!wr_pend_ff) begin
                  wr_entry_ff <= rd_entry;
               end
            end
            tsa_pkg::FSM_WRITE: begin
               num_ff <= DW'(23'(first_next_ff) + 23'(second_next_ff)) * DW'(100);
               rem_ff <= '0;
               quot_ff <= '0;
               dcnt_ff <= 5'(DW - 1);
            end
            tsa_pkg::FSM_CLEAR: begin
               sweep_ff <= AW'(sweep_ff + AW'(1));
               if (sweep_ff == AW'(SLOT_COUNT - 1)) begin
                  wr_entry_ff <= '0;
                  sel_ok_ff <= 1'b0;
                  num_ff <= '0;
                  rem_ff <= '0;
                  quot_ff <= '0;
                  dcnt_ff <= 5'(DW - 1);
               end
            end
            tsa_pkg::FSM_DIV: begin
               // restoring division, one quotient bit per cycle
               if ({rem_ff[DW-2:0], num_ff[DW-1]} >= DW'(total)) begin
                  rem_ff <= {rem_ff[DW-2:0], num_ff[DW-1]} - DW'(total);
                  quot_ff <= {quot_ff[DW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[DW-2:0], num_ff[DW-1]};
                  quot_ff <= {quot_ff[DW-2:0], 1'b0};
               end
               num_ff <= {num_ff[DW-2:0], 1'b0};
               dcnt_ff <= dcnt_ff - 5'd1;
            end
            default: ;
         endcase
      end
   end

   // Result assembly; the slot percentage divides by a constant.
   wire [6:0]  mem_pct = (total == 23'd0) ? 7'd100 :
                         (quot_ff > DW'(100)) ? 7'd100 : 7'(quot_ff);
   wire [6:0]  slot_pct = 7'((32'(latest_ff) * 32'd100) / SLOT_COUNT);
   wire        space = (first_free > 23'(tsa_pkg::SPACE_MARGIN) ||
                        second_free > 23'(tsa_pkg::SPACE_MARGIN)) &&
                       (CW'(latest_ff) + CW'(2) < SLOT_MAX);
   wire        loc = sel_ok_ff && wr_entry_ff.valid;
   // Bind and query echo the low 9 bits of the requested slot number, even out of range.
   wire [8:0]  slot_echo = (act == tsa_pkg::ACT_BIND || act == tsa_pkg::ACT_QUERY) ?
                           req_ff.slot[8:0] : 9'(sel_ff);

   always_ff @(posedge clock) begin
      if (state_ff == tsa_pkg::FSM_OUT && out_go) begin
         rsp_ff.status <= status_ff;
         rsp_ff.slot_out <= slot_echo;
         rsp_ff.location_valid <= loc;
         rsp_ff.location_second_arena <= loc & wr_entry_ff.second_arena;
         rsp_ff.location_offset <= loc ? wr_entry_ff.offset[20:0] : 21'd0;
         rsp_ff.allocated_bytes <= loc ? wr_entry_ff.size : 21'd0;
         rsp_ff.can_hold <= hold_ff;
         rsp_ff.usage_percent <= (mem_pct > slot_pct) ? mem_pct : slot_pct;
         rsp_ff.space_available <= space;
      end
   end

   `TSA_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != tsa_pkg::FSM_IDLE, !req_ready, "accept while busy")
   `TSA_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == tsa_pkg::FSM_OUT && out_go, rsp_valid, "result not raised")
   `TSA_ASSERT_IMPL(a_latest_range, clock, reset, 1'b1, CW'(latest_ff) < SLOT_MAX, "latest slot out of range")
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the texture slot arena allocator.
`timescale 1ns / 1ps
module tb_top;
   localparam int NSLOT = 512;
   localparam int SECOND_SIZE = 2097152;
   localparam int ALIGN = 16;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tsa_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tsa_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [21:0] csr_data = '0;

   always #4 clock = ~clock;

   texture_slot_arena_allocator_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Shadow copy of the slot table and arena pointers.
   logic        sh_valid [NSLOT];
   logic        sh_second [NSLOT];
   logic [31:0] sh_offset [NSLOT];
   logic [31:0] sh_size [NSLOT];
   logic [31:0] sh_first_next, sh_second_next, sh_latest, sh_bound;
   logic        sh_bound_ok;
   logic [31:0] sh_first_bytes;

   tsa_pkg::rsp_type expected_rsp[$];
   int errors = 0;
   int send_idle = 0;  // percent
   int recv_idle = 0;
   bit recv_hold = 0;
   int quiet_cycles = 0;

   task automatic wipe_table();
      for (int i = 0; i < NSLOT; i++) begin
         sh_valid[i] = 1'b0; sh_second[i] = 1'b0; sh_offset[i] = 0; sh_size[i] = 0;
      end
      sh_first_next = 0; sh_second_next = 0; sh_latest = 0;
   endtask

   function automatic logic [31:0] round_up(logic [31:0] n);
      return ((n + ALIGN - 1) / ALIGN) * ALIGN;
   endfunction

   function automatic bit first_has(logic [31:0] n);
      return sh_first_next <= sh_first_bytes && sh_first_bytes - sh_first_next >= n;
   endfunction

   // Apply one request to the shadow state and return the response it yields.
   task automatic predict_allocation(input tsa_pkg::req_type rq, output tsa_pkg::rsp_type rs);
      logic [31:0] sel, need, raw, px, used, total, mem, slots, ffree;
      logic [1:0] st;
      bit sel_ok, hold;
      sel = 0; st = tsa_pkg::ST_DONE; sel_ok = 0; hold = 0;
      case (rq.action)
         tsa_pkg::ACT_CREATE: begin
            if (sh_latest + 1 >= NSLOT) begin
               st = tsa_pkg::ST_IGNORED; sel = sh_latest;
            end else begin
               sh_latest++;
               sh_valid[sh_latest] = 1'b0; sh_second[sh_latest] = 1'b0;
               sh_offset[sh_latest] = 0; sh_size[sh_latest] = 0;
               sh_bound = sh_latest; sh_bound_ok = 1; sel = sh_latest; sel_ok = 1;
            end
         end
         tsa_pkg::ACT_BIND: begin
            sel = 32'(rq.slot);
            if (rq.slot >= NSLOT) st = tsa_pkg::ST_IGNORED;
            else begin
               sh_bound = 32'(rq.slot); sh_bound_ok = 1; sel_ok = 1;
            end
         end
         tsa_pkg::ACT_RESERVE: begin
            if (!sh_bound_ok || sh_bound >= NSLOT) st = tsa_pkg::ST_IGNORED;
            else begin
               px = 32'(rq.width) * 32'(rq.height);
               case (rq.pixel_format)
                  3'd0: raw = px >> 1;
                  3'd1: raw = px;
                  3'd2: raw = px * 2;
                  3'd3: raw = px * 4;
                  default: raw = 0;
               endcase
               need = round_up(raw);
               sel = sh_bound; sel_ok = 1;
               if (sh_valid[sel] && sh_size[sel] >= need) st = tsa_pkg::ST_REUSED;
               else begin
                  if (first_has(need)) begin
                     sh_second[sel] = 1'b0; sh_offset[sel] = sh_first_next;
                     sh_first_next += need;
                  end else if (SECOND_SIZE - sh_second_next >= need) begin
                     sh_second[sel] = 1'b1; sh_offset[sel] = sh_second_next;
                     sh_second_next += need;
                  end else begin
                     sh_second[sel] = 1'b0; sh_offset[sel] = 0; st = tsa_pkg::ST_OVERFLOW;
                  end
                  sh_valid[sel] = 1'b1;
                  sh_size[sel] = need > 32'h1FFFFF ? 32'h1FFFFF : need;
               end
            end
         end
         tsa_pkg::ACT_CLEAR: begin
            wipe_table(); sh_bound_ok = 0; sh_bound = 0;
         end
         tsa_pkg::ACT_QUERY: begin
            need = round_up(32'(rq.query_bytes));
            sel = 32'(rq.slot);
            if (rq.slot < NSLOT) begin
               sel_ok = 1;
               if (sh_valid[rq.slot] && sh_size[rq.slot] >= need) hold = 1;
            end
            if (first_has(need) || SECOND_SIZE - sh_second_next >= need) hold = 1;
         end
         default: st = tsa_pkg::ST_IGNORED;
      endcase
      used = sh_first_next + sh_second_next;
      total = sh_first_bytes + SECOND_SIZE;
      mem = 32'((64'(used) * 100) / total);
      if (mem > 100) mem = 100;
      slots = sh_latest * 100 / NSLOT;
      ffree = sh_first_next <= sh_first_bytes ? sh_first_bytes - sh_first_next : 0;
      rs = '0;
      rs.status = st;
      rs.slot_out = sel[8:0];
      if (sel_ok && sh_valid[sel]) begin
         rs.location_valid = 1'b1;
         rs.location_second_arena = sh_second[sel];
         rs.location_offset = sh_offset[sel][20:0];
         rs.allocated_bytes = sh_size[sel][20:0];
      end
      rs.can_hold = hold;
      rs.usage_percent = 7'(mem > slots ? mem : slots);
      rs.space_available = (ffree > tsa_pkg::SPACE_MARGIN ||
                            SECOND_SIZE - sh_second_next > tsa_pkg::SPACE_MARGIN)
                           && sh_latest + 2 < NSLOT;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Send one transaction: random leading gap, then hold valid until accepted.
   // Valid is left high after the accept; the caller drops it when done.
   task automatic send_request(input tsa_pkg::req_type rq);
      tsa_pkg::rsp_type rs;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_allocation(rq, rs);
      expected_rsp.push_back(rs);
   endtask

   task automatic write_arena_size(input logic [21:0] bytes);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= bytes;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sh_first_bytes = 32'(bytes);
   endtask

   function automatic tsa_pkg::req_type make_req(tsa_pkg::action_type a, int s, int w, int h,
                                                 int f, int q);
      tsa_pkg::req_type r;
      r.action = a; r.slot = 10'(s); r.width = 10'(w); r.height = 10'(h);
      r.pixel_format = 3'(f); r.query_bytes = 21'(q);
      return r;
   endfunction

   function automatic tsa_pkg::req_type random_req();
      tsa_pkg::req_type r;
      int pick;
      r = '0;
      r.slot = 10'($urandom_range(99) < 85 ? $urandom_range(40) : $urandom_range(1023));
      r.width = 10'($urandom_range(99) < 80 ? $urandom_range(1, 64) : $urandom_range(1, 1023));
      r.height = 10'($urandom_range(99) < 80 ? $urandom_range(1, 64) : $urandom_range(1, 1023));
      r.pixel_format = 3'($urandom_range(7));
      r.query_bytes = 21'($urandom_range(99) < 70 ? $urandom_range(70000) : $urandom());
      pick = $urandom_range(199);
      if (pick < 40) r.action = tsa_pkg::ACT_CREATE;
      else if (pick < 80) r.action = tsa_pkg::ACT_BIND;
      else if (pick < 150) r.action = tsa_pkg::ACT_RESERVE;
      else if (pick < 152) r.action = tsa_pkg::ACT_CLEAR;
      else if (pick < 190) r.action = tsa_pkg::ACT_QUERY;
      else r.action = tsa_pkg::action_type'($urandom_range(5, 7));
      return r;
   endfunction

   // Response side: random stalls plus an optional long hold-off.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
   end

   // Compare each accepted response against the oldest expectation.
   always @(posedge clock) begin
      tsa_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) report_mismatch("unexpected response", 1, 0);
         else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.slot_out != want.slot_out)
               report_mismatch("slot_out", 32'(rsp_data.slot_out), 32'(want.slot_out));
            if (rsp_data.location_valid != want.location_valid)
               report_mismatch("location_valid", 32'(rsp_data.location_valid),
                               32'(want.location_valid));
            if (rsp_data.location_second_arena != want.location_second_arena)
               report_mismatch("location_second_arena", 32'(rsp_data.location_second_arena),
                               32'(want.location_second_arena));
            if (rsp_data.location_offset != want.location_offset)
               report_mismatch("location_offset", 32'(rsp_data.location_offset),
                               32'(want.location_offset));
            if (rsp_data.allocated_bytes != want.allocated_bytes)
               report_mismatch("allocated_bytes", 32'(rsp_data.allocated_bytes),
                               32'(want.allocated_bytes));
            if (rsp_data.can_hold != want.can_hold)
               report_mismatch("can_hold", 32'(rsp_data.can_hold), 32'(want.can_hold));
            if (rsp_data.usage_percent != want.usage_percent)
               report_mismatch("usage_percent", 32'(rsp_data.usage_percent),
                               32'(want.usage_percent));
            if (rsp_data.space_available != want.space_available)
               report_mismatch("space_available", 32'(rsp_data.space_available),
                               32'(want.space_available));
         end
      end
   end

   // Watchdog: counts cycles with no transaction on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Edge cases: create up to full table, bounds, formats, extremes, clear.
   task automatic test_directed();
      send_request(make_req(tsa_pkg::ACT_RESERVE, 0, 1, 1, 0, 0));       // slot 0 bound at reset
      send_request(make_req(tsa_pkg::ACT_RESERVE, 0, 1, 1, 0, 0));       // reuse
      send_request(make_req(tsa_pkg::ACT_CREATE, 0, 1, 1, 0, 0));
      send_request(make_req(tsa_pkg::ACT_RESERVE, 0, 512, 512, 3, 0));   // 1 MiB, big
      send_request(make_req(tsa_pkg::ACT_CREATE, 0, 1, 1, 0, 0));
      send_request(make_req(tsa_pkg::ACT_RESERVE, 0, 1023, 1023, 3, 0)); // saturated size
      send_request(make_req(tsa_pkg::ACT_RESERVE, 0, 1023, 1023, 3, 0)); // saturated, not reused
      send_request(make_req(tsa_pkg::ACT_RESERVE, 0, 3, 5, 1, 0));
      send_request(make_req(tsa_pkg::ACT_RESERVE, 0, 7, 9, 2, 0));
      send_request(make_req(tsa_pkg::ACT_RESERVE, 0, 7, 9, 7, 0));       // zero-size format
      send_request(make_req(tsa_pkg::ACT_BIND, 1023, 1, 1, 0, 0));      // out of range
      send_request(make_req(tsa_pkg::ACT_BIND, 511, 1, 1, 0, 0));
      send_request(make_req(tsa_pkg::ACT_QUERY, 1, 1, 1, 0, 1048576));
      send_request(make_req(tsa_pkg::ACT_QUERY, 1023, 1, 1, 0, 2097151));
      send_request(make_req(tsa_pkg::ACT_QUERY, 2, 1, 1, 0, 0));
      send_request(make_req(tsa_pkg::action_type'(3'd7), 0, 1, 1, 0, 0));
      send_request(make_req(tsa_pkg::action_type'(3'd5), 0, 1, 1, 0, 0));
      send_request(make_req(tsa_pkg::ACT_CLEAR, 0, 1, 1, 0, 0));
      send_request(make_req(tsa_pkg::ACT_RESERVE, 0, 4, 4, 0, 0));       // nothing bound
      repeat (512) send_request(make_req(tsa_pkg::ACT_CREATE, 0, 1, 1, 0, 0)); // full table
      send_request(make_req(tsa_pkg::ACT_CLEAR, 0, 1, 1, 0, 0));
      req_valid <= 1'b0;
   endtask

   task automatic test_random(input int count);
      repeat (count) send_request(random_req());
      req_valid <= 1'b0;
   endtask

   // Fill the pipe while the response side holds off, then drain.
   task automatic test_backpressure();
      fork
         begin
            recv_hold = 1;
            repeat (300) @(posedge clock);
            recv_hold = 0;
         end
         test_random(20);
      join
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      wipe_table();
      sh_bound = 0; sh_bound_ok = 1; sh_first_bytes = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_arena_size(22'd2097152);
      test_directed();
      send_idle = 14; recv_idle = 51;
      test_random(250);
      write_arena_size(22'd100000);
      send_idle = 51; recv_idle = 14;
      test_random(250);
      write_arena_size(22'd0);
      test_backpressure();
      write_arena_size(22'h3FFFFF);
      send_idle = 0; recv_idle = 0;
      test_random(200);
      write_arena_size(22'd4096);
      test_random(20);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
